@@ design/binary_to_zeckendorf_unit_defines.svh @@
// Assertion macros for the Zeckendorf converter.
`ifndef BINARY_TO_ZECKENDORF_UNIT_DEFINES_SVH
`define BINARY_TO_ZECKENDORF_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// prop must hold at every rising clock edge outside reset
`define B2Z_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("b2z assertion failed");
// cond must never be true outside reset
`define B2Z_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("b2z forbidden condition seen");
`else
`define B2Z_ASSERT(lbl, clk, rst, prop)
`define B2Z_ASSERT_NEVER(lbl, clk, rst, cond)
`endif

`endif

@@ design/b2z_pkg.sv @@
`default_nettype none

package b2z_pkg;

  localparam int INPUT_WIDTH = 64;          // value bits that take part
  localparam int VALUE_W     = 64;
  localparam int NUM_DIGITS  = 92;
  localparam int DIG_LO_W    = 64;
  localparam int DIG_HI_W    = NUM_DIGITS - DIG_LO_W;
  localparam int CNT_W       = 7;
  localparam int NUM_STAGES  = NUM_DIGITS / 2;  // two digits per stage
  localparam int OUT_FIELDS_W = NUM_DIGITS + CNT_W;
  localparam int OUT_DATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [VALUE_W-1:0] IN_MASK = {VALUE_W{1'b1}} >> (VALUE_W - INPUT_WIDTH);

  // Weight of digit k: F(k+2), i.e. 1, 2, 3, 5, ...
  function automatic logic [VALUE_W-1:0] fib_weight(input int unsigned k);
    logic [VALUE_W-1:0] a;
    logic [VALUE_W-1:0] b;
    logic [VALUE_W-1:0] t;
    a = VALUE_W'(1);
    b = VALUE_W'(2);
    for (int unsigned i = 0; i < k; i++) begin
      t = a + b;
      a = b;
      b = t;
    end
    return a;
  endfunction

endpackage

`default_nettype wire

@@ design/binary_to_zeckendorf_unit.sv @@
`default_nettype none
// Channel   Dir  Width  Fields (lsb first)
// s_*       in   64     value[63:0]
// m_*       out  104    digits_low[63:0], digits_high[91:64], digit_count[98:92], zero pad
//
// One item per cycle while s_tready is high; an input register, 46 stages that
// each resolve two digits with a pair of 64-bit subtractors, and an output register.
// The digit pair subtractors set the stage depth.
// rst is synchronous and clears only valid bits.
// A skid register behind the output holds one item when m_tready drops; the
// pipeline then freezes and s_tready falls until the skid drains.

`include "binary_to_zeckendorf_unit_defines.svh"

module binary_to_zeckendorf_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [b2z_pkg::VALUE_W-1:0]     s_tdata,   // value
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [b2z_pkg::OUT_DATA_W-1:0]       m_tdata    // digits_low, digits_high, digit_count
);

  localparam int NS  = b2z_pkg::NUM_STAGES;
  localparam int ND  = b2z_pkg::NUM_DIGITS;
  localparam int VW  = b2z_pkg::VALUE_W;
  localparam int CW  = b2z_pkg::CNT_W;

  logic            en;
  logic [NS:0]     vld_q;
  logic [VW-1:0]   rem_q [0:NS];
  logic [ND-1:0]   dig_q [0:NS];
  logic [CW-1:0]   cnt_q [0:NS];

  logic            out_valid;
  logic [ND-1:0]   out_dig;
  logic [CW-1:0]   out_cnt;
  logic            skid_valid;
  logic [ND-1:0]   skid_dig;
  logic [CW-1:0]   skid_cnt;

  assign en       = !skid_valid;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-1:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= s_tdata & b2z_pkg::IN_MASK;
      dig_q[0] <= '0;
      cnt_q[0] <= CW'(1);
    end
  end

  for (genvar j = 0; j < NS; j++) begin : g_stage
    localparam int KH = ND - 1 - 2 * j;
    localparam int KL = KH - 1;
    localparam logic [VW-1:0] WH = b2z_pkg::fib_weight(KH);
    localparam logic [VW-1:0] WL = b2z_pkg::fib_weight(KL);

    logic [VW:0]   diff_h;
    logic [VW:0]   diff_l;
    logic [VW-1:0] rem_next;
    logic [ND-1:0] dig_next;
    logic [CW-1:0] cnt_next;

    // Remainder is below weight KH+1 on entry, so setting digit KH
    // leaves it below weight KL and digit KL stays clear.
    always_comb begin
      diff_h   = {1'b0, rem_q[j]} - {1'b0, WH};
      diff_l   = {1'b0, rem_q[j]} - {1'b0, WL};
      rem_next = rem_q[j];
      dig_next = dig_q[j];
      cnt_next = cnt_q[j];
      if (!diff_h[VW]) begin
        rem_next     = diff_h[VW-1:0];
        dig_next[KH] = 1'b1;
        if (cnt_q[j] == CW'(1)) cnt_next = CW'(KH + 1);
      end else if (!diff_l[VW]) begin
        rem_next     = diff_l[VW-1:0];
        dig_next[KL] = 1'b1;
        if (cnt_q[j] == CW'(1)) cnt_next = CW'(KL + 1);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[j+1] <= rem_next;
        dig_q[j+1] <= dig_next;
        cnt_q[j+1] <= cnt_next;
      end
    end
  end

  // output register plus skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_tready) begin
        out_dig    <= skid_dig;
        out_cnt    <= skid_cnt;
        skid_valid <= 1'b0;
      end
    end else if (vld_q[NS]) begin
      if (!out_valid || m_tready) begin
        out_valid <= 1'b1;
        out_dig   <= dig_q[NS];
        out_cnt   <= cnt_q[NS];
      end else begin
        skid_valid <= 1'b1;
        skid_dig   <= dig_q[NS];
        skid_cnt   <= cnt_q[NS];
      end
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(b2z_pkg::OUT_DATA_W - b2z_pkg::OUT_FIELDS_W)'(0), out_cnt, out_dig};

  `B2Z_ASSERT_NEVER(a_skid_behind_out, clk, rst, skid_valid && !out_valid)
  `B2Z_ASSERT(a_no_adjacent_digits, clk, rst,
    out_valid |-> ((out_dig & (out_dig >> 1)) == '0))
  `B2Z_ASSERT(a_count_marks_top, clk, rst,
    out_valid |-> ((out_dig >> out_cnt) == '0 && out_cnt != '0))

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int VALUE_W    = b2z_pkg::VALUE_W;
  localparam int NUM_DIGITS = b2z_pkg::NUM_DIGITS;
  localparam int DIG_LO_W   = b2z_pkg::DIG_LO_W;
  localparam int DIG_HI_W   = b2z_pkg::DIG_HI_W;
  localparam int CNT_W      = b2z_pkg::CNT_W;
  localparam int OUT_DATA_W = b2z_pkg::OUT_DATA_W;

  typedef struct {
    logic [DIG_LO_W-1:0] digits_low;
    logic [DIG_HI_W-1:0] digits_high;
    logic [CNT_W-1:0]    digit_count;
  } zeck_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_PATTERN,
    RX_SLOW
  } rx_mode_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 120;
  localparam int RANDOM_ITEMS   = 1100;
  localparam int REPORT_MAX     = 10;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [VALUE_W-1:0]    s_tdata = '0;       // value
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;            // digits_low, digits_high, digit_count, pad

  logic [VALUE_W-1:0] fib_w [NUM_DIGITS];
  logic [VALUE_W-1:0] value_q [$];
  zeck_t              zeck_due [$];
  int                 mismatches = 0;
  int                 burst_left = 1;
  int                 gap_left = 0;
  int                 seg_left = 0;
  int                 rx_phase = 0;
  int                 idle_cycles = 0;
  rx_mode_t           rx_mode = RX_OPEN;

  binary_to_zeckendorf_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // greedy pick from the top Fibonacci weight down
  function automatic zeck_t zeck_of(input logic [VALUE_W-1:0] value);
    logic [VALUE_W-1:0]    rem;
    logic [NUM_DIGITS-1:0] dig;
    zeck_t                 r;
    int                    k;
    rem = value & b2z_pkg::IN_MASK;
    dig = '0;
    r.digit_count = CNT_W'(1);
    for (k = NUM_DIGITS - 1; k >= 0; k--) begin
      if (fib_w[k] <= rem) begin
        rem = rem - fib_w[k];
        dig[k] = 1'b1;
        if (r.digit_count < CNT_W'(k + 1)) r.digit_count = CNT_W'(k + 1);
      end
    end
    r.digits_low  = dig[DIG_LO_W-1:0];
    r.digits_high = dig[NUM_DIGITS-1:DIG_LO_W];
    return r;
  endfunction

  task automatic queue_value(input logic [VALUE_W-1:0] v);
    value_q.insert(value_q.size(), v);
  endtask

  // stimulus
  initial begin
    logic [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] alt_sum;
    int                 k;
    int                 n;
    fib_w[0] = VALUE_W'(1);
    fib_w[1] = VALUE_W'(2);
    for (k = 2; k < NUM_DIGITS; k++) fib_w[k] = fib_w[k-1] + fib_w[k-2];

    // directed: zero, tiny values, extremes, Fibonacci edges, alternating-digit patterns
    queue_value('0);
    queue_value(VALUE_W'(1));
    queue_value(VALUE_W'(2));
    queue_value(VALUE_W'(3));
    queue_value(VALUE_W'(4));
    queue_value('1);
    queue_value(fib_w[NUM_DIGITS-1]);
    queue_value(fib_w[NUM_DIGITS-1] - 1);
    queue_value(fib_w[NUM_DIGITS-1] + 1);
    queue_value(fib_w[NUM_DIGITS-2]);
    queue_value(fib_w[NUM_DIGITS-2] - 1);
    queue_value(fib_w[63]);
    queue_value(fib_w[64]);
    queue_value(fib_w[64] - 1);
    queue_value(VALUE_W'(1) << (VALUE_W - 1));
    queue_value((VALUE_W'(1) << (VALUE_W - 1)) - 1);
    queue_value({(VALUE_W/4){4'hA}});
    queue_value({(VALUE_W/4){4'h5}});
    queue_value(VALUE_W'(32'hFFFF_FFFF));
    queue_value(VALUE_W'(33'h1_0000_0000));
    alt_sum = '0;
    for (k = 0; k < NUM_DIGITS; k += 2) alt_sum = alt_sum + fib_w[k];
    queue_value(alt_sum);
    alt_sum = '0;
    for (k = 1; k < DIG_LO_W; k += 2) alt_sum = alt_sum + fib_w[k];
    queue_value(alt_sum);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      case ($urandom_range(0, 5))
        0, 1: v = {$urandom, $urandom};
        2: v = {$urandom, $urandom} >> $urandom_range(0, VALUE_W - 1);
        3: begin
          k = $urandom_range(0, NUM_DIGITS - 1);
          v = fib_w[k] + VALUE_W'($urandom_range(0, 2)) - VALUE_W'(1);
        end
        4: begin
          // random set of non-adjacent digits
          v = '0;
          for (k = 0; k < NUM_DIGITS - 1; k++) begin
            if ($urandom_range(0, 2) == 0) begin
              v = v + fib_w[k];
              k++;
            end
          end
        end
        default: v = VALUE_W'($urandom_range(0, 400));
      endcase
      queue_value(v);
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // sender: bursts with random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) zeck_due.insert(zeck_due.size(), zeck_of(s_tdata));
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (value_q.size() != 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= value_q.pop_front();
          if (burst_left <= 1) begin
            burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                      : $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: ready pattern switches between modes over segments
  always @(posedge clk) begin
    if (seg_left == 0) begin
      seg_left <= $urandom_range(20, 300);
      rx_mode  <= rx_mode_t'($urandom_range(0, 3));
    end else begin
      seg_left <= seg_left - 1;
    end
    rx_phase <= rx_phase + 1;
    case (rx_mode)
      RX_OPEN:    m_tready <= 1'b1;
      RX_COIN:    m_tready <= ($urandom_range(0, 1) == 1);
      RX_PATTERN: m_tready <= (rx_phase % 5 == 0) || (rx_phase % 5 == 3);
      default:    m_tready <= ($urandom_range(0, 11) == 0) ? !m_tready : m_tready;
    endcase
  end

  // checker
  always @(posedge clk) begin
    zeck_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (zeck_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result transfer: tdata=%h", m_tdata);
      end else begin
        want = zeck_due.pop_front();
        if (m_tdata[DIG_LO_W-1:0] !== want.digits_low ||
            m_tdata[NUM_DIGITS-1:DIG_LO_W] !== want.digits_high ||
            m_tdata[NUM_DIGITS+CNT_W-1:NUM_DIGITS] !== want.digit_count) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("mismatch: exp lo=%h hi=%h cnt=%0d, got lo=%h hi=%h cnt=%0d",
                     want.digits_low, want.digits_high, want.digit_count,
                     m_tdata[DIG_LO_W-1:0], m_tdata[NUM_DIGITS-1:DIG_LO_W],
                     m_tdata[NUM_DIGITS+CNT_W-1:NUM_DIGITS]);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    do @(posedge clk);
    while (rst || value_q.size() != 0 || s_tvalid || zeck_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && zeck_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
